### rtl/core/mbc_pkg.sv
package mbc_pkg;

  // fixed field widths
  localparam int REQ_W  = 2;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int RND_W  = 8;
  localparam int STAT_W = 3;
  localparam int BITS_W = 4;
  localparam int GRID_W = 7;
  localparam int CMP_W  = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_STARTED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_CARVED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BACK    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DONE    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_READ    = 3'd4;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WRAP_C = 2'd2;
  localparam logic [1:0] REG_WRAP_R = 2'd3;

  // neighbour directions, also the passage bit positions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_START_CLR, S_RD_ISSUE, S_RD_DATA, S_STK_RD, S_TOP,
    S_NB_RD, S_NB_CHK, S_CHOOSE, S_SELF_RD, S_SELF_WR, S_OTH_RD, S_OTH_WR,
    S_POP_RD, S_POP_TOP, S_POP_CELL, S_POP_DATA, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_CLR, ST_RD_NB, ST_RD_SELF, ST_WR_SELF, ST_RD_OTH, ST_WR_OTH, ST_RD_CELL
  } store_op_t;

  typedef enum logic [2:0] {
    SK_NONE, SK_RD_TOP, SK_PUSH, SK_START, SK_POP
  } stack_op_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_START, RES_READ, RES_FIN, RES_BACK, RES_CARVE
  } res_sel_t;

  typedef struct packed {
    store_op_t store_op;
    stack_op_t stack_op;
    res_sel_t  res_sel;
    logic      latch_req;
    logic      latch_top;
    logic      nb_chk;
    logic      choose;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] in_req;
    logic             clr_done;
    logic             dir_last;
    logic             count_zero;
    logic             any_free;
    logic             out_free;
  } sts_t;

  // random byte mod n for n in 1..4
  function automatic logic [1:0] rnd_pick(input logic [RND_W-1:0] rnd,
                                          input logic [2:0] n);
    logic [3:0] s;
    logic [2:0] s2;
    logic [1:0] m3;
    s  = 4'(rnd[1:0]) + 4'(rnd[3:2]) + 4'(rnd[5:4]) + 4'(rnd[7:6]);
    s2 = 3'(s[1:0]) + 3'(s[3:2]);
    unique case (s2)
      3'd0, 3'd3, 3'd6: m3 = 2'd0;
      3'd1, 3'd4, 3'd7: m3 = 2'd1;
      default:          m3 = 2'd2;
    endcase
    unique case (n)
      3'd2:    rnd_pick = {1'b0, rnd[0]};
      3'd3:    rnd_pick = m3;
      3'd4:    rnd_pick = rnd[1:0];
      default: rnd_pick = 2'd0;
    endcase
  endfunction

  function automatic logic [BITS_W-1:0] dir_bit(input logic [1:0] d);
    dir_bit = BITS_W'(1) << d;
  endfunction

  function automatic logic [1:0] dir_opp(input logic [1:0] d);
    unique case (d)
      DIR_UP:   dir_opp = DIR_DOWN;
      DIR_DOWN: dir_opp = DIR_UP;
      DIR_LEFT: dir_opp = DIR_RIGHT;
      default:  dir_opp = DIR_LEFT;
    endcase
  endfunction

endpackage

### rtl/core/mbc_ctrl.sv
module mbc_ctrl
  import mbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RST_CLR:   if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          priority case (sts.in_req)
            REQ_START: state_nxt = S_START_CLR;
            REQ_STEP:  state_nxt = S_STK_RD;
            REQ_READ:  state_nxt = S_RD_ISSUE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_START_CLR: if (sts.clr_done) state_nxt = S_EMIT;
      S_RD_ISSUE:  state_nxt = S_RD_DATA;
      S_RD_DATA:   state_nxt = S_EMIT;
      S_STK_RD:    state_nxt = sts.count_zero ? S_EMIT : S_TOP;
      S_TOP:       state_nxt = S_NB_RD;
      S_NB_RD:     state_nxt = S_NB_CHK;
      S_NB_CHK:    state_nxt = sts.dir_last ? S_CHOOSE : S_NB_RD;
      S_CHOOSE:    state_nxt = sts.any_free ? S_SELF_RD : S_POP_RD;
      S_SELF_RD:   state_nxt = S_SELF_WR;
      S_SELF_WR:   state_nxt = S_OTH_RD;
      S_OTH_RD:    state_nxt = S_OTH_WR;
      S_OTH_WR:    state_nxt = S_EMIT;
      S_POP_RD:    state_nxt = sts.count_zero ? S_EMIT : S_POP_TOP;
      S_POP_TOP:   state_nxt = S_POP_CELL;
      S_POP_CELL:  state_nxt = S_POP_DATA;
      S_POP_DATA:  state_nxt = S_EMIT;
      S_EMIT:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_RST_CLR: cmd.store_op = ST_CLR;
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.latch_req = in_tvalid;
      end
      S_START_CLR: begin
        cmd.store_op = ST_CLR;
        if (sts.clr_done) begin
          cmd.stack_op = SK_START;
          cmd.res_sel  = RES_START;
        end
      end
      S_RD_ISSUE: cmd.store_op = ST_RD_CELL;
      S_RD_DATA:  cmd.res_sel  = RES_READ;
      S_STK_RD: begin
        if (sts.count_zero) cmd.res_sel  = RES_FIN;
        else                cmd.stack_op = SK_RD_TOP;
      end
      S_TOP:      cmd.latch_top = 1'b1;
      S_NB_RD:    cmd.store_op  = ST_RD_NB;
      S_NB_CHK:   cmd.nb_chk    = 1'b1;
      S_CHOOSE: begin
        cmd.choose = 1'b1;
        if (!sts.any_free) cmd.stack_op = SK_POP;
      end
      S_SELF_RD:  cmd.store_op = ST_RD_SELF;
      S_SELF_WR:  cmd.store_op = ST_WR_SELF;
      S_OTH_RD:   cmd.store_op = ST_RD_OTH;
      S_OTH_WR: begin
        cmd.store_op = ST_WR_OTH;
        cmd.stack_op = SK_PUSH;
        cmd.res_sel  = RES_CARVE;
      end
      S_POP_RD: begin
        if (sts.count_zero) cmd.res_sel  = RES_FIN;
        else                cmd.stack_op = SK_RD_TOP;
      end
      S_POP_TOP:  cmd.latch_top = 1'b1;
      S_POP_CELL: cmd.store_op  = ST_RD_SELF;
      S_POP_DATA: cmd.res_sel   = RES_BACK;
      S_EMIT:     cmd.emit      = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

### rtl/core/mbc_datapath.sv
module mbc_datapath
  import mbc_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // req_type, cell_col, cell_row, random_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status, pos_col, pos_row, passages
  input  logic [GRID_W-1:0]     grid_w,
  input  logic [GRID_W-1:0]     grid_h,
  input  logic                  wrap_c,
  input  logic                  wrap_r,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // memories
  logic [BITS_W-1:0] store_mem [DEPTH];
  logic [RW+CW-1:0]  stack_mem [DEPTH];

  logic [IW-1:0]     st_addr;
  logic              st_we, st_re;
  logic [BITS_W-1:0] st_wdata, st_rdata_r;
  logic [RW+CW-1:0]  stk_rdata_r;

  // request and walk registers
  logic [COL_W-1:0]  req_col_r;
  logic [ROW_W-1:0]  req_row_r;
  logic [RND_W-1:0]  rnd_r;
  logic [CW-1:0]     c_r, oth_c_r;
  logic [RW-1:0]     r_r, oth_r_r;
  logic [1:0]        dir_r, sel_r;
  logic [3:0]        free_r;
  logic [CNT_W-1:0]  count_r;
  logic [IW-1:0]     clr_cnt_r;

  logic [STAT_W-1:0] res_stat_r;
  logic [COL_W-1:0]  res_col_r;
  logic [ROW_W-1:0]  res_row_r;
  logic [BITS_W-1:0] res_bits_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [GRID_W-1:0] eff_w, eff_h;
  logic [CW-1:0]     wm1, sat_c;
  logic [RW-1:0]     hm1, sat_r;
  logic              in_grid, req_in_range;
  logic [CW-1:0]     nb_col [4];
  logic [RW-1:0]     nb_row [4];
  logic [3:0]        nb_en;
  logic [2:0]        n_free;
  logic [1:0]        pick_k, pick_dir;
  logic [2:0]        scan_cnt;
  logic [IW-1:0]     self_idx, oth_idx, nb_idx, cell_idx;
  logic              clr_last;

  // effective grid size
  always_comb begin
    if (grid_w == '0)                               eff_w = GRID_W'(1);
    else if (CMP_W'(grid_w) > CMP_W'(MAX_COLS))     eff_w = GRID_W'(MAX_COLS);
    else                                            eff_w = grid_w;
    if (grid_h == '0)                               eff_h = GRID_W'(1);
    else if (CMP_W'(grid_h) > CMP_W'(MAX_ROWS))     eff_h = GRID_W'(MAX_ROWS);
    else                                            eff_h = grid_h;
  end

  assign wm1 = CW'(eff_w - GRID_W'(1));
  assign hm1 = RW'(eff_h - GRID_W'(1));

  assign sat_c = (CMP_W'(req_col_r) >= CMP_W'(eff_w)) ? wm1 : CW'(req_col_r);
  assign sat_r = (CMP_W'(req_row_r) >= CMP_W'(eff_h)) ? hm1 : RW'(req_row_r);
  assign req_in_range = (CMP_W'(req_col_r) < CMP_W'(MAX_COLS)) &&
                        (CMP_W'(req_row_r) < CMP_W'(MAX_ROWS));

  // neighbours of the top cell
  assign in_grid = (CMP_W'(c_r) < CMP_W'(eff_w)) && (CMP_W'(r_r) < CMP_W'(eff_h));

  always_comb begin
    nb_col[DIR_UP]    = c_r;
    nb_row[DIR_UP]    = (r_r == '0) ? hm1 : RW'(r_r - 1'b1);
    nb_col[DIR_DOWN]  = c_r;
    nb_row[DIR_DOWN]  = (r_r == hm1) ? '0 : RW'(r_r + 1'b1);
    nb_col[DIR_LEFT]  = (c_r == '0) ? wm1 : CW'(c_r - 1'b1);
    nb_row[DIR_LEFT]  = r_r;
    nb_col[DIR_RIGHT] = (c_r == wm1) ? '0 : CW'(c_r + 1'b1);
    nb_row[DIR_RIGHT] = r_r;
    nb_en[DIR_UP]     = in_grid && (wrap_r || r_r != '0);
    nb_en[DIR_DOWN]   = in_grid && (wrap_r || r_r != hm1);
    nb_en[DIR_LEFT]   = in_grid && (wrap_c || c_r != '0);
    nb_en[DIR_RIGHT]  = in_grid && (wrap_c || c_r != wm1);
  end

  // pick the k-th free neighbour
  always_comb begin
    n_free = 3'(free_r[0]) + 3'(free_r[1]) + 3'(free_r[2]) + 3'(free_r[3]);
    pick_k = rnd_pick(rnd_r, n_free);
    pick_dir = DIR_UP;
    scan_cnt = '0;
    for (int d = 0; d < 4; d++) begin
      if (free_r[d]) begin
        if (scan_cnt == 3'(pick_k)) pick_dir = 2'(d);
        scan_cnt = scan_cnt + 3'd1;
      end
    end
  end

  assign self_idx = IW'(IW'(r_r) * IW'(MAX_COLS) + IW'(c_r));
  assign oth_idx  = IW'(IW'(oth_r_r) * IW'(MAX_COLS) + IW'(oth_c_r));
  assign nb_idx   = IW'(IW'(nb_row[dir_r]) * IW'(MAX_COLS) + IW'(nb_col[dir_r]));
  assign cell_idx = IW'(IW'(RW'(req_row_r)) * IW'(MAX_COLS) + IW'(CW'(req_col_r)));
  assign clr_last = (clr_cnt_r == IW'(DEPTH - 1));

  // passage store port
  always_comb begin
    st_addr  = clr_cnt_r;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_wdata = '0;
    unique case (cmd.store_op)
      ST_CLR:     st_we = 1'b1;
      ST_RD_NB:   begin st_addr = nb_idx;   st_re = 1'b1; end
      ST_RD_SELF: begin st_addr = self_idx; st_re = 1'b1; end
      ST_RD_OTH:  begin st_addr = oth_idx;  st_re = 1'b1; end
      ST_RD_CELL: begin st_addr = cell_idx; st_re = 1'b1; end
      ST_WR_SELF: begin
        st_addr  = self_idx;
        st_we    = 1'b1;
        st_wdata = st_rdata_r | dir_bit(sel_r);
      end
      ST_WR_OTH: begin
        st_addr  = oth_idx;
        st_we    = 1'b1;
        st_wdata = st_rdata_r | dir_bit(dir_opp(sel_r));
      end
      default: st_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_addr] <= st_wdata;
    if (st_re) st_rdata_r <= store_mem[st_addr];
  end

  // position stack
  always_ff @(posedge clk) begin
    unique case (cmd.stack_op)
      SK_START:  stack_mem[0] <= {sat_r, sat_c};
      SK_PUSH:   if (count_r < CNT_W'(DEPTH))
                   stack_mem[count_r[IW-1:0]] <= {oth_r_r, oth_c_r};
      SK_RD_TOP: stk_rdata_r <= stack_mem[IW'(count_r - 1'b1)];
      default:   ;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      clr_cnt_r <= '0;
      dir_r     <= DIR_UP;
    end else begin
      unique case (cmd.stack_op)
        SK_START: count_r <= CNT_W'(1);
        SK_PUSH:  if (count_r < CNT_W'(DEPTH)) count_r <= CNT_W'(count_r + 1'b1);
        SK_POP:   count_r <= CNT_W'(count_r - 1'b1);
        default:  ;
      endcase
      if (cmd.store_op == ST_CLR) clr_cnt_r <= clr_last ? '0 : IW'(clr_cnt_r + 1'b1);
      if (cmd.latch_top)   dir_r <= DIR_UP;
      else if (cmd.nb_chk) dir_r <= 2'(dir_r + 1'b1);
    end
  end

  // request, top cell and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_col_r  <= in_tdata[7:2];
      req_row_r  <= in_tdata[13:8];
      rnd_r      <= in_tdata[21:14];
    end
    if (cmd.latch_top) begin
      c_r    <= stk_rdata_r[CW-1:0];
      r_r    <= stk_rdata_r[RW+CW-1:CW];
      free_r <= '0;
    end else if (cmd.nb_chk) begin
      free_r[dir_r] <= nb_en[dir_r] && (st_rdata_r == '0);
    end
    if (cmd.choose) begin
      sel_r   <= pick_dir;
      oth_c_r <= nb_col[pick_dir];
      oth_r_r <= nb_row[pick_dir];
    end
    unique case (cmd.res_sel)
      RES_START: begin
        res_stat_r <= STAT_STARTED;
        res_col_r  <= COL_W'(sat_c);
        res_row_r  <= ROW_W'(sat_r);
        res_bits_r <= '0;
      end
      RES_READ: begin
        res_stat_r <= STAT_READ;
        res_col_r  <= req_col_r;
        res_row_r  <= req_row_r;
        res_bits_r <= req_in_range ? st_rdata_r : '0;
      end
      RES_FIN: begin
        res_stat_r <= STAT_DONE;
        res_col_r  <= '0;
        res_row_r  <= '0;
        res_bits_r <= '0;
      end
      RES_BACK: begin
        res_stat_r <= STAT_BACK;
        res_col_r  <= COL_W'(c_r);
        res_row_r  <= ROW_W'(r_r);
        res_bits_r <= st_rdata_r;
      end
      RES_CARVE: begin
        res_stat_r <= STAT_CARVED;
        res_col_r  <= COL_W'(oth_c_r);
        res_row_r  <= ROW_W'(oth_r_r);
        res_bits_r <= st_rdata_r | dir_bit(dir_opp(sel_r));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {5'd0, res_bits_r, res_row_r, res_col_r, res_stat_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    sts.in_req     = in_tdata[1:0];
    sts.clr_done   = clr_last;
    sts.dir_last   = (dir_r == DIR_RIGHT);
    sts.count_zero = (count_r == '0);
    sts.any_free   = |free_r;
    sts.out_free   = !out_tvalid_r || out_tready;
  end

endmodule

### rtl/core/maze_backtracker_carver_core.sv
// randomized depth-first maze carver over a grid of up to MAX_COLS x MAX_ROWS
// cells, one request in flight at a time. after reset the passage store is
// cleared, one cell per cycle, before the first request is taken
// (configuration writes are accepted meanwhile). a start request runs the
// same clearing sweep. a carve step makes one stack read, four neighbour
// reads through the single passage store port, then a read-modify-write of
// both cells; a backtrack makes the same neighbour reads, then pops the
// stack and reads the new top cell. results wait in an output register, so
// a new request is taken while the last result is still pending
module maze_backtracker_carver_core
  import mbc_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // req_type[1:0], cell_col[7:2], cell_row[13:8],
                                            // random_value[21:14]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status[2:0], pos_col[8:3], pos_row[14:9],
                                            // passages[18:15]
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [GRID_W-1:0] grid_w_r, grid_h_r;
  logic              wrap_c_r, wrap_r_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  cmd_t              cmd;
  sts_t              sts;

  // register file, one register per word
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_W'(64);
      grid_h_r <= GRID_W'(64);
      wrap_c_r <= 1'b0;
      wrap_r_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  grid_w_r <= cfg_pwdata[GRID_W-1:0];
        REG_HEIGHT: grid_h_r <= cfg_pwdata[GRID_W-1:0];
        REG_WRAP_C: wrap_c_r <= cfg_pwdata[0];
        default:    wrap_r_r <= cfg_pwdata[0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  cfg_prdata = CFG_DATA_W'(grid_w_r);
      REG_HEIGHT: cfg_prdata = CFG_DATA_W'(grid_h_r);
      REG_WRAP_C: cfg_prdata = CFG_DATA_W'(wrap_c_r);
      default:    cfg_prdata = CFG_DATA_W'(wrap_r_r);
    endcase
  end

  // sequencer
  mbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // passage store, position stack and result register
  mbc_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .grid_w     (grid_w_r),
    .grid_h     (grid_h_r),
    .wrap_c     (wrap_c_r),
    .wrap_r     (wrap_r_r),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### verif/maze_backtracker_carver_core_tb.sv
`timescale 1ns / 100ps

module maze_backtracker_carver_core_tb;
  import mbc_pkg::*;

  localparam int CELLS      = 64 * 64;
  localparam int TARGET     = 1550;
  localparam int CYCLE_CAP  = 2000000;
  localparam int SETTLE     = 60;    // covers a carve step plus slack after the last result
  localparam int HOLD_LONG  = 800;   // long receiver hold-off, in cycles

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BITS_W-1:0] bits;
  } maze_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  maze_backtracker_carver_core uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the block: passage bits, path stack, register copies
  logic [BITS_W-1:0] maze_cells [CELLS];
  logic [COL_W-1:0]  path_col [CELLS];
  logic [ROW_W-1:0]  path_row [CELLS];
  int                path_depth = 0;
  logic [GRID_W-1:0] m_width = 7'd64, m_height = 7'd64;
  logic              m_wrap_c = 1'b0, m_wrap_r = 1'b0;

  logic [IN_DATA_W-1:0] req_q [$];    // requests waiting to be offered
  maze_res_t            maze_exp_q [$];

  int errors = 0;
  int n_carve = 0, n_back = 0, n_done = 0, n_read = 0, n_phase = 0;
  int made = 0;
  int cycles = 0;
  bit calm = 1'b0;      // set for stretches without idling
  int hold_token = 0;   // bumped to ask for a long receiver hold-off

  function automatic logic [IN_DATA_W-1:0] pack_req(logic [1:0] kind, int c, int r, int rnd);
    return {2'b00, 8'(rnd), 6'(r), 6'(c), kind};
  endfunction

  function automatic int eff(logic [GRID_W-1:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // expected result for one accepted request, updates the mirror
  task automatic carve_predict(input logic [IN_DATA_W-1:0] d);
    logic [1:0] kind;
    int c, r, rnd, w, h, n, k, nr, nc, idx;
    int cand_c [4];
    int cand_r [4];
    int cand_d [4];
    maze_res_t e;
    kind = d[1:0];
    c = d[7:2];
    r = d[13:8];
    rnd = d[21:14];
    w = eff(m_width);
    h = eff(m_height);
    n = 0;
    if (kind == REQ_START) begin
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      foreach (maze_cells[i]) maze_cells[i] = '0;
      path_col[0] = c;
      path_row[0] = r;
      path_depth = 1;
      e = '{STAT_STARTED, c, r, 0};
    end else if (kind == REQ_READ) begin
      e = '{STAT_READ, c, r, maze_cells[r * 64 + c]};
    end else if (kind != REQ_STEP) begin
      return;   // unknown request, no result
    end else if (path_depth == 0) begin
      e = '{STAT_DONE, 0, 0, 0};
    end else begin
      c = path_col[path_depth - 1];
      r = path_row[path_depth - 1];
      if (c < w && r < h) begin
        if (m_wrap_r || r != 0) begin
          nr = (r == 0) ? h - 1 : r - 1;
          if (maze_cells[nr * 64 + c] == 0) begin
            cand_c[n] = c; cand_r[n] = nr; cand_d[n] = DIR_UP; n++;
          end
        end
        if (m_wrap_r || r != h - 1) begin
          nr = (r + 1 == h) ? 0 : r + 1;
          if (maze_cells[nr * 64 + c] == 0) begin
            cand_c[n] = c; cand_r[n] = nr; cand_d[n] = DIR_DOWN; n++;
          end
        end
        if (m_wrap_c || c != 0) begin
          nc = (c == 0) ? w - 1 : c - 1;
          if (maze_cells[r * 64 + nc] == 0) begin
            cand_c[n] = nc; cand_r[n] = r; cand_d[n] = DIR_LEFT; n++;
          end
        end
        if (m_wrap_c || c != w - 1) begin
          nc = (c + 1 == w) ? 0 : c + 1;
          if (maze_cells[r * 64 + nc] == 0) begin
            cand_c[n] = nc; cand_r[n] = r; cand_d[n] = DIR_RIGHT; n++;
          end
        end
      end
      if (n == 0) begin
        path_depth--;
        if (path_depth == 0) begin
          e = '{STAT_DONE, 0, 0, 0};
        end else begin
          c = path_col[path_depth - 1];
          r = path_row[path_depth - 1];
          e = '{STAT_BACK, c, r, maze_cells[r * 64 + c]};
        end
      end else begin
        k = rnd % n;
        // opposite direction is the partner bit: up/down and left/right
        maze_cells[r * 64 + c] |= BITS_W'(1) << cand_d[k];
        idx = cand_r[k] * 64 + cand_c[k];
        maze_cells[idx] |= BITS_W'(1) << (cand_d[k] ^ 1);
        if (path_depth < CELLS) begin
          path_col[path_depth] = cand_c[k];
          path_row[path_depth] = cand_r[k];
          path_depth++;
        end
        e = '{STAT_CARVED, cand_c[k], cand_r[k], maze_cells[idx]};
      end
    end
    maze_exp_q.push_back(e);
  endtask

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  // request driver: acceptance seen at the rising edge, new values at the falling edge
  bit in_took = 1'b0;
  int in_gap = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t timeout, %0d results still expected", $time, maze_exp_q.size());
      $display("FAILURE");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      carve_predict(in_tdata);
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        in_tdata <= req_q.pop_front();
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  int hold_left = 0;
  int hold_seen = 0;
  int out_gap = 0;

  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_LONG;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    maze_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[2:0], out_tdata[8:3], out_tdata[14:9], out_tdata[18:15]};
      if (maze_exp_q.size() == 0) begin
        $display("%0t unexpected result transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = maze_exp_q.pop_front();
        if (got.status != want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.col != want.col) begin
          $display("%0t pos_col: expected %0d actual %0d", $time, want.col, got.col);
          errors++;
        end
        if (got.row != want.row) begin
          $display("%0t pos_row: expected %0d actual %0d", $time, want.row, got.row);
          errors++;
        end
        if (got.bits != want.bits) begin
          $display("%0t passages: expected %h actual %h", $time, want.bits, got.bits);
          errors++;
        end
        case (got.status)
          STAT_CARVED: n_carve++;
          STAT_BACK:   n_back++;
          STAT_DONE:   n_done++;
          STAT_READ:   n_read++;
          default: ;
        endcase
      end
    end
  end

  // register write, setup then access phase; only used while the block is idle
  task automatic cfg_write(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(idx) << 2;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  m_width = 7'(val);
      REG_HEIGHT: m_height = 7'(val);
      REG_WRAP_C: m_wrap_c = val[0];
      default:    m_wrap_r = val[0];
    endcase
  endtask

  // everything offered, accepted and answered, then let a silent request drain
  task automatic wait_quiet();
    while (req_q.size() > 0 || in_tvalid || maze_exp_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(input int w, input int h, input int wc, input int wr);
    wait_quiet();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_WRAP_C, wc);
    cfg_write(REG_WRAP_R, wr);
  endtask

  task automatic add_req(input logic [1:0] kind, input int c, input int r, input int rnd);
    req_q.push_back(pack_req(kind, c, r, rnd));
    if (kind != 2'd3) made++;
  endtask

  // steps with random choice bytes, sprinkled with reads, noise and restarts
  task automatic add_walk(input int steps);
    int pick;
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        add_req(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      else if (pick < 13)
        add_req(2'd3, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      else if (pick < 14)
        add_req(REQ_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      else
        add_req(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int w, h, mode, steps;
    bit pressed;
    pressed = 1'b0;
    foreach (maze_cells[i]) maze_cells[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty stack, far corner start on the default grid, noise, reads
    add_req(REQ_STEP, 0, 0, 0);
    add_req(REQ_READ, 0, 0, 255);
    add_req(2'd3, 63, 63, 255);
    add_req(REQ_START, 63, 63, 255);
    add_req(REQ_STEP, 0, 0, 255);
    add_req(REQ_STEP, 63, 63, 0);
    add_req(REQ_STEP, 0, 0, 3);
    add_req(REQ_READ, 63, 63, 0);
    add_req(REQ_READ, 62, 63, 0);
    // out-of-range sizes: zero acts as one, 127 as the maximum, start saturates
    set_grid(0, 127, 1, 1);
    add_req(REQ_START, 40, 63, 0);
    add_req(REQ_STEP, 0, 0, 1);
    add_req(REQ_STEP, 0, 0, 2);
    add_req(REQ_STEP, 0, 0, 3);
    add_req(REQ_READ, 0, 63, 0);
    // single cell with wrap: the cell is its own neighbour
    set_grid(1, 1, 1, 1);
    add_req(REQ_START, 5, 5, 0);
    add_req(REQ_STEP, 0, 0, 0);
    add_req(REQ_STEP, 0, 0, 0);
    add_req(REQ_STEP, 0, 0, 0);
    add_req(REQ_READ, 0, 0, 0);
    add_req(REQ_STEP, 0, 0, 0);

    while (made < TARGET) begin
      n_phase++;
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin w = 1; h = $urandom_range(1, 2); end
        1: begin w = 64; h = $urandom_range(1, 2); end
        2: begin w = $urandom_range(1, 3); h = 64; end
        3: begin w = $urandom_range(0, 1) ? 0 : 127; h = $urandom_range(0, 3); end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
      endcase
      set_grid(w, h, $urandom_range(0, 1), $urandom_range(0, 1));
      calm = ($urandom_range(0, 5) == 0);
      steps = 2 * eff(7'(w)) * eff(7'(h)) + 3;
      if (steps > 70) steps = 70;
      if ($urandom_range(0, 1))
        add_req(REQ_START, $urandom_range(0, eff(7'(w)) - 1),
                $urandom_range(0, eff(7'(h)) - 1), 0);
      else
        add_req(REQ_START, $urandom_range(0, 63), $urandom_range(0, 63), 0);
      // one phase parks the receiver so the block backs up onto its input
      if (!pressed && n_phase == 3) begin
        pressed = 1'b1;
        hold_token++;
      end
      add_walk(steps);
      // shrink the grid under a live stack now and then
      if ($urandom_range(0, 5) == 0) begin
        set_grid($urandom_range(1, 2), $urandom_range(1, 2),
                 $urandom_range(0, 1), $urandom_range(0, 1));
        add_walk(12);
      end
    end

    wait_quiet();
    $display("phases %0d, requests %0d, carved %0d, backtracked %0d, finished %0d, reads %0d",
             n_phase, made, n_carve, n_back, n_done, n_read);
    $display("grids from 1x1 to 64 wide, with and without wrap, sizes out of range included");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/mbc_pkg.sv
rtl/core/mbc_ctrl.sv
rtl/core/mbc_datapath.sv
rtl/core/maze_backtracker_carver_core.sv
verif/maze_backtracker_carver_core_tb.sv
